>>> rtl/core/software_timer_bank_unit_macros.svh
// ----------------------------------------------------------------------------
// software_timer_bank_unit_macros
// assertion macros for the timer bank, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_UNIT_MACROS_SVH
`define SOFTWARE_TIMER_BANK_UNIT_MACROS_SVH

`ifndef SYNTH
`define STB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// types and codes shared by the software timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 72;

    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD        = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_PERIOD = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_LOOKUP,
        ST_DIVIDE,
        ST_RESP
    } state_t;

    // one timer slot as held in the memory
    typedef struct packed {
        logic                expired;
        logic [PERIOD_W-1:0] count;
        logic [PERIOD_W-1:0] period;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PERIOD_W-1:0] period_ticks;
        logic [PERIOD_W-1:0] count_value;
        logic                expired;
    } result_t;

endpackage

>>> rtl/core/software_timer_bank_unit.sv
// accept to result valid: a tick with slots via ST_TICK, add and set period via ST_DIVIDE,
// restart and query via ST_LOOKUP, all then ST_RESP; errors and others only ST_RESP
// the next request is accepted once the result is loaded; a held output stalls it
// a tick walks the slot memory one entry per cycle (read, then write back)
// the period divide is a reciprocal multiply plus a one-step correction
// reset clears the slot count and the control state; slot memory is not cleared
`include "software_timer_bank_unit_macros.svh"
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// bank of one-shot tick timers kept in a synchronous slot memory
// ----------------------------------------------------------------------------
module software_timer_bank_unit #(
    parameter int unsigned NUM_TIMERS = 8,
    parameter int unsigned TICK_MS    = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // timer_index[2:0], period_ms[34:3], zero pad
    input  logic [stb_pkg::IN_W-1:0]   s_axis_tdata,
    // op[2:0]
    input  logic [stb_pkg::OP_W-1:0]   s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status[1:0], slot_count[5:2], period_ticks[37:6], count_value[69:38],
    // expired[70], zero pad
    output logic [stb_pkg::OUT_W-1:0]  m_axis_tdata
);
    import stb_pkg::*;

    localparam int unsigned CNT_W     = $clog2(NUM_TIMERS + 1);
    localparam int unsigned IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int unsigned DIV_STEPS = 2;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
    // reciprocal of the tick length, scaled so that it fits in one word
    localparam int unsigned DIV_SHIFT = PERIOD_W - 1 + $clog2(TICK_MS);
    localparam logic [PERIOD_W-1:0] DIV_MUL =
        PERIOD_W'((64'd1 << DIV_SHIFT) / 64'(TICK_MS));
    localparam logic [PERIOD_W-1:0] TICK_DIV = PERIOD_W'(TICK_MS);

    // input fields
    logic [OP_W-1:0]     in_op;
    logic [INDEX_W-1:0]  in_index;
    logic [PERIOD_W-1:0] in_ms;

    assign in_op    = s_axis_tuser;
    assign in_index = s_axis_tdata[INDEX_W-1:0];
    assign in_ms    = s_axis_tdata[INDEX_W +: PERIOD_W];

    // registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    tick_idx_reg, tick_idx_next;
    logic [PERIOD_W-1:0] dq_reg, dq_next;
    logic [PERIOD_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    result_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    // slot memory
    entry_t              mem [NUM_TIMERS];
    entry_t              mem_q_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;

    // decode of the incoming request
    logic                accept;
    logic                is_full;
    logic                is_short;
    logic                is_bad;
    logic [CNT_W-1:0]    tick_nxt;
    logic                tick_more;
    logic                out_free;
    logic [2*PERIOD_W-1:0] div_prod;
    logic [PERIOD_W-1:0] div_est;
    logic [PERIOD_W-1:0] div_rem;
    logic [PERIOD_W-1:0] quotient;
    entry_t              tick_upd;
    logic [PERIOD_W-1:0] tick_cnt;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_full  = (cnt_reg >= CNT_W'(NUM_TIMERS));
    assign is_short = (in_ms < PERIOD_W'(TICK_MS));
    assign is_bad   = (CMP_W'(in_index) >= CMP_W'(cnt_reg));
    assign tick_nxt  = CNT_W'(tick_idx_reg) + CNT_W'(1);
    assign tick_more = (tick_nxt < cnt_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // estimate is exact or one short, the remainder check fixes it
    assign div_prod = (2*PERIOD_W)'(dq_reg) * (2*PERIOD_W)'(DIV_MUL);
    assign div_est  = PERIOD_W'(div_prod >> DIV_SHIFT);
    assign div_rem  = dq_reg - PERIOD_W'(quo_reg * TICK_DIV);
    assign quotient = (div_rem >= TICK_DIV) ? quo_reg + PERIOD_W'(1) : quo_reg;

    // tick update of the entry read in the previous cycle
    always_comb
    begin
        tick_cnt = mem_q_reg.expired ? mem_q_reg.count : mem_q_reg.count + PERIOD_W'(1);
        tick_upd.period  = mem_q_reg.period;
        tick_upd.count   = tick_cnt;
        tick_upd.expired = mem_q_reg.expired || (tick_cnt >= mem_q_reg.period);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.expired, out_res_reg.count_value,
                            out_res_reg.period_ticks, out_slot_reg, out_res_reg.status};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_TICK:
                            state_next = (cnt_reg != '0) ? ST_TICK : ST_RESP;
                        OP_ADD:
                            state_next = (is_full || is_short) ? ST_RESP : ST_DIVIDE;
                        OP_RESTART, OP_QUERY:
                            state_next = is_bad ? ST_RESP : ST_LOOKUP;
                        OP_SET_PERIOD:
                            state_next = (is_bad || is_short) ? ST_RESP : ST_DIVIDE;
                        default:
                            state_next = ST_RESP;
                    endcase
                end
            end
            ST_TICK:
            begin
                if (!tick_more)
                    state_next = ST_RESP;
            end
            ST_LOOKUP:
                state_next = ST_RESP;
            ST_DIVIDE:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        tick_idx_next  = tick_idx_reg;
        dq_next        = dq_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        out_slot_next  = out_slot_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_op;
                    addr_next = (in_op == OP_ADD) ? IDX_W'(cnt_reg) : IDX_W'(in_index);
                    dq_next   = in_ms;
                    step_next = '0;
                    res_next  = '0;
                    case (in_op)
                        OP_TICK:
                        begin
                            rd_en         = (cnt_reg != '0);
                            rd_addr       = '0;
                            tick_idx_next = '0;
                        end
                        OP_ADD:
                        begin
                            if (is_full)
                                res_next.status = STATUS_FULL;
                            else if (is_short)
                                res_next.status = STATUS_SHORT;
                        end
                        OP_RESTART, OP_QUERY:
                        begin
                            if (is_bad)
                                res_next.status = STATUS_BAD_IDX;
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = IDX_W'(in_index);
                            end
                        end
                        OP_SET_PERIOD:
                        begin
                            if (is_bad)
                                res_next.status = STATUS_BAD_IDX;
                            else if (is_short)
                                res_next.status = STATUS_SHORT;
                        end
                        default:
                            res_next = '0;
                    endcase
                end
            end
            ST_TICK:
            begin
                wr_en   = 1'b1;
                wr_addr = tick_idx_reg;
                wr_data = tick_upd;
                if (tick_more)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = IDX_W'(tick_nxt);
                    tick_idx_next = IDX_W'(tick_nxt);
                end
            end
            ST_LOOKUP:
            begin
                res_next.status       = STATUS_OK;
                res_next.period_ticks = mem_q_reg.period;
                if (op_reg == OP_RESTART)
                begin
                    wr_en                = 1'b1;
                    wr_data.period       = mem_q_reg.period;
                    res_next.count_value = '0;
                    res_next.expired     = 1'b0;
                end
                else
                begin
                    res_next.count_value = mem_q_reg.count;
                    res_next.expired     = mem_q_reg.expired;
                end
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    wr_en                 = 1'b1;
                    wr_data.period        = quotient;
                    res_next.status       = STATUS_OK;
                    res_next.period_ticks = quotient;
                    res_next.count_value  = '0;
                    res_next.expired      = 1'b0;
                    if (op_reg == OP_ADD)
                        cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                    quo_next = div_est;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_slot_next  = SLOT_W'(cnt_reg);
                end
            end
            default:
                res_next = res_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        tick_idx_reg <= tick_idx_next;
        dq_reg       <= dq_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
        out_slot_reg <= out_slot_next;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    `STB_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(NUM_TIMERS))
    `STB_ASSERT_IMPL(a_cnt_step, clk, rst_n, !$stable(cnt_reg), cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `STB_ASSERT_IMPL(a_tick_range, clk, rst_n, state_reg == ST_TICK, CNT_W'(tick_idx_reg) < cnt_reg)
    `STB_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, !s_axis_tready)

endmodule
